@@ rtl/assert_macros.svh @@
// assertion macros for the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dqi_pkg.sv @@
// shared constants, request codes and interface structs of the indexed deque
// no dependencies
package dqi_pkg;

    localparam int CAPACITY      = 1024;
    localparam int ELEMENT_WIDTH = 32;

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // word field widths
    localparam int REQ_W = 3;
    localparam int POS_W = 10;
    localparam int VAL_W = 32;

    localparam int IN_FIELDS_W  = POS_W + VAL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = VAL_W + 1 + CNT_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // output word bit positions
    localparam int OUT_OK_BIT    = VAL_W;
    localparam int OUT_CNT_LSB   = VAL_W + 1;
    localparam int OUT_EMPTY_BIT = VAL_W + 1 + CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_L = 3'd0,
        REQ_PUSH_R = 3'd1,
        REQ_POP_L  = 3'd2,
        REQ_POP_R  = 3'd3,
        REQ_GET    = 3'd4,
        REQ_SET    = 3'd5,
        REQ_PEEK_L = 3'd6,
        REQ_PEEK_R = 3'd7
    } t_req;

    typedef struct packed {
        logic                     we;
        logic                     re;
        logic [PTR_W-1:0]         addr;
        logic [ELEMENT_WIDTH-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic             ok;
        logic             rd;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_rsp_meta;

endpackage

@@ rtl/dqi_ram.sv @@
// single-port synchronous element memory, registered read data
// no dependencies
module dqi_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/dqi_ctrl.sv @@
// end pointer and element count, request decode and slot address generation
// depends on dqi_pkg
module dqi_ctrl
    import dqi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_req             i_req,
    input  logic [POS_W-1:0] i_position,
    input  logic [VAL_W-1:0] i_value,
    output t_mem_req         o_mem,
    output t_rsp_meta        o_meta
);

    logic [PTR_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_count, n_count;

    logic             full, empty, pos_ok, done, wr, rd;
    logic [PTR_W-1:0] left_dec, left_inc, logical;
    logic [PTR_W:0]   slot_sum;
    logic [PTR_W-1:0] slot;

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign pos_ok   = (CNT_W'(i_position) < r_count) && (POS_W <= CNT_W ||
                      i_position < POS_W'(CAPACITY));
    assign left_dec = (r_left == '0) ? PTR_W'(CAPACITY - 1) : r_left - 1'b1;
    assign left_inc = (r_left == PTR_W'(CAPACITY - 1)) ? '0 : r_left + 1'b1;

    // wrap left + logical index; both below capacity so one subtract suffices
    assign slot_sum = {1'b0, r_left} + {1'b0, logical};
    assign slot     = (slot_sum >= (PTR_W + 1)'(CAPACITY)) ?
                      PTR_W'(slot_sum - (PTR_W + 1)'(CAPACITY)) : PTR_W'(slot_sum);

    always_comb begin
        n_left  = r_left;
        n_count = r_count;
        logical = '0;
        done    = 1'b0;
        wr      = 1'b0;
        rd      = 1'b0;
        unique case (i_req)
            REQ_PUSH_L: begin
                done = !full;
                wr   = !full;
                if (!full) begin
                    n_left  = left_dec;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PUSH_R: begin
                done    = !full;
                wr      = !full;
                logical = PTR_W'(r_count);
                if (!full) begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_L: begin
                done = !empty;
                if (!empty) begin
                    n_left  = left_inc;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_POP_R: begin
                done = !empty;
                if (!empty) begin
                    n_count = r_count - 1'b1;
                end
            end
            REQ_GET: begin
                done    = pos_ok;
                rd      = pos_ok;
                logical = PTR_W'(i_position);
            end
            REQ_SET: begin
                done    = pos_ok;
                wr      = pos_ok;
                logical = PTR_W'(i_position);
            end
            REQ_PEEK_L: begin
                done = !empty;
                rd   = !empty;
            end
            REQ_PEEK_R: begin
                done    = !empty;
                rd      = !empty;
                logical = PTR_W'(r_count - 1'b1);
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

    always_comb begin
        o_mem.we    = i_accept && wr;
        o_mem.re    = i_accept && rd;
        o_mem.addr  = (i_req == REQ_PUSH_L) ? left_dec : slot;
        o_mem.wdata = ELEMENT_WIDTH'(i_value);

        o_meta.ok    = done;
        o_meta.rd    = rd;
        o_meta.count = n_count;
        o_meta.empty = (n_count == '0);
    end

endmodule

@@ rtl/double_ended_queue_indexed.sv @@
// indexed double-ended queue on a ring buffer held in one synchronous memory
// result path: memory read into stage one, then the output register
// throughput: one request per cycle while the result side is not stalled, set by the single memory port
// a read of the element memory follows every earlier write, so no forwarding
// reset clears the end pointer, the element count and the pipeline; the
// element memory is not cleared (only written entries are ever read)
module double_ended_queue_indexed
    import dqi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // position, value_in, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // value_out, ok, element_count, is_empty, zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic                     accept, out_free, s1_move;
    t_mem_req                 mem;
    t_rsp_meta                meta;
    logic [ELEMENT_WIDTH-1:0] rdata;
    logic [VAL_W-1:0]         value_out;

    logic                     r_s1_valid, r_out_valid;
    t_rsp_meta                r_s1_meta;
    logic [OUT_DATA_W-1:0]    r_out_data;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    dqi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (t_req'(i_s_axis_tuser)),
        .i_position (i_s_axis_tdata[POS_W-1:0]),
        .i_value    (i_s_axis_tdata[POS_W +: VAL_W]),
        .o_mem      (mem),
        .o_meta     (meta)
    );

    dqi_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_re    (mem.re),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (rdata)
    );

    // stage one waits on the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    assign value_out = r_s1_meta.rd ? VAL_W'(rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= OUT_DATA_W'({r_s1_meta.empty, r_s1_meta.count,
                                       r_s1_meta.ok, value_out});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

@@ rtl/dqi_checker.sv @@
// port-level checks on the result words of the indexed deque, bound to the top
// depends on dqi_pkg and assert_macros.svh
`include "assert_macros.svh"

module dqi_checker
    import dqi_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [CNT_W-1:0] cnt;
    logic             ok_bit, empty_bit;

    assign cnt       = o_m_axis_tdata[OUT_CNT_LSB +: CNT_W];
    assign ok_bit    = o_m_axis_tdata[OUT_OK_BIT];
    assign empty_bit = o_m_axis_tdata[OUT_EMPTY_BIT];

    `ASSERT_NOW(a_empty_matches_count, i_clk, i_rst_n, o_m_axis_tvalid, empty_bit == (cnt == '0), "empty flag disagrees with element count")
    `ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, o_m_axis_tvalid, cnt <= CNT_W'(CAPACITY), "element count above capacity")
    `ASSERT_NOW(a_refused_reads_zero, i_clk, i_rst_n, o_m_axis_tvalid && !ok_bit, o_m_axis_tdata[VAL_W-1:0] == '0, "refused request returned data")
    `ASSERT_NEXT(a_stalled_word_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result word changed")

endmodule

bind double_ended_queue_indexed dqi_checker u_dqi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ sim/dqi_result_checker.sv @@
// result checker for the indexed deque: tracks queue contents from accepted request words
// and compares every accepted result word with the oldest predicted one
// depends on dqi_pkg for widths, field positions and request codes
`timescale 1ns / 1ps

module dqi_result_checker
    import dqi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    // position, value_in, zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]      i_s_axis_tuser,
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // value_out, ok, element_count, is_empty, zero pad
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_level
);

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             ok;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_result;

    logic [ELEMENT_WIDTH-1:0] slots [CAPACITY];
    logic [PTR_W-1:0]         left_end;
    logic [CNT_W-1:0]         level;
    t_result                  awaited [$];

    // applies one request to the tracked queue and gives the result word it causes
    task automatic apply_request(input t_req kind, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val, output t_result res);
        res.value = '0;
        res.ok    = 1'b0;
        case (kind)
            REQ_PUSH_L: begin
                if (level < CAPACITY) begin
                    left_end = PTR_W'((left_end + CAPACITY - 1) % CAPACITY);
                    slots[left_end] = val;
                    level++;
                    res.ok = 1'b1;
                end
            end
            REQ_PUSH_R: begin
                if (level < CAPACITY) begin
                    slots[(left_end + level) % CAPACITY] = val;
                    level++;
                    res.ok = 1'b1;
                end
            end
            REQ_POP_L: begin
                if (level != 0) begin
                    left_end = PTR_W'((left_end + 1) % CAPACITY);
                    level--;
                    res.ok = 1'b1;
                end
            end
            REQ_POP_R: begin
                if (level != 0) begin
                    level--;
                    res.ok = 1'b1;
                end
            end
            REQ_GET: begin
                if (pos < level) begin
                    res.value = slots[(left_end + pos) % CAPACITY];
                    res.ok    = 1'b1;
                end
            end
            REQ_SET: begin
                if (pos < level) begin
                    slots[(left_end + pos) % CAPACITY] = val;
                    res.ok = 1'b1;
                end
            end
            REQ_PEEK_L: begin
                if (level != 0) begin
                    res.value = slots[left_end];
                    res.ok    = 1'b1;
                end
            end
            default: begin
                if (level != 0) begin
                    res.value = slots[(left_end + level - 1) % CAPACITY];
                    res.ok    = 1'b1;
                end
            end
        endcase
        res.count = level;
        res.empty = (level == 0);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            left_end = '0;
            level    = '0;
            awaited.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.value = i_m_axis_tdata[VAL_W-1:0];
                got.ok    = i_m_axis_tdata[OUT_OK_BIT];
                got.count = i_m_axis_tdata[OUT_CNT_LSB +: CNT_W];
                got.empty = i_m_axis_tdata[OUT_EMPTY_BIT];
                if (awaited.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result word: value %h ok %0d count %0d empty %0d",
                                 got.value, got.ok, got.count, got.empty);
                    o_errors++;
                end else begin
                    want = awaited.pop_front();
                    if (got.value !== want.value || got.ok !== want.ok ||
                        got.count !== want.count || got.empty !== want.empty) begin
                        if (o_errors < 10) begin
                            $display("mismatch: expected value %h ok %0d count %0d empty %0d",
                                     want.value, want.ok, want.count, want.empty);
                            $display("          got      value %h ok %0d count %0d empty %0d",
                                     got.value, got.ok, got.count, got.empty);
                        end
                        o_errors++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_request(t_req'(i_s_axis_tuser), i_s_axis_tdata[POS_W-1:0],
                              i_s_axis_tdata[POS_W +: VAL_W], want);
                awaited.push_back(want);
            end
        end
        o_pending = awaited.size();
        o_level   = int'(level);
    end

endmodule

@@ sim/double_ended_queue_indexed_test.sv @@
// top of the indexed deque testbench: clock, reset, request stimulus and verdict
// depends on dqi_pkg, double_ended_queue_indexed and dqi_result_checker
`timescale 1ns / 1ps

module double_ended_queue_indexed_test;
    import dqi_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 16;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data;
    logic [REQ_W-1:0]      s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;

    bit send_gaps;
    bit sink_stalls;
    int errors;
    int pending;
    int level;

    double_ended_queue_indexed uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    dqi_result_checker u_results (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_level         (level)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // entered and left at a falling edge, so the next word can follow without a gap
    task automatic send_word(input t_req kind, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        if (send_gaps && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, val, pos};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // mostly valid positions, pushes favoured while the queue is short
    task automatic random_request();
        int               r;
        t_req             kind;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < 10)
            kind = t_req'(REQ_W'($urandom_range(0, 7)));
        else if (r < ((level < 8) ? 50 : 38))
            kind = $urandom_range(0, 1) ? REQ_PUSH_R : REQ_PUSH_L;
        else if (r < 62)
            kind = $urandom_range(0, 1) ? REQ_POP_R : REQ_POP_L;
        else begin
            case ($urandom_range(0, 3))
                0:       kind = REQ_GET;
                1:       kind = REQ_SET;
                2:       kind = REQ_PEEK_L;
                default: kind = REQ_PEEK_R;
            endcase
        end
        if (level != 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, level - 1));
        else
            pos = POS_W'($urandom_range(0, CAPACITY - 1));
        send_word(kind, pos, $urandom);
    endtask

    // sink side back-pressure
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [POS_W-1:0] pos;
        s_valid     = 1'b0;
        s_data      = '0;
        s_user      = REQ_PUSH_L;
        rst_n       = 1'b0;
        send_gaps   = 1'b1;
        sink_stalls = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // refusals on an empty queue
        send_word(REQ_POP_L,  '0, '0);
        send_word(REQ_POP_R,  '0, '0);
        send_word(REQ_PEEK_L, '0, '0);
        send_word(REQ_PEEK_R, '0, '0);
        send_word(REQ_GET,    '0, '0);
        send_word(REQ_SET,    '0, 32'hFFFF_FFFF);
        // left push from slot zero wraps the ring
        send_word(REQ_PUSH_L, '0, 32'hFFFF_FFFF);
        send_word(REQ_PUSH_R, 10'h3FF, 32'h0000_0000);
        send_word(REQ_PUSH_L, '0, 32'hA5A5_5A5A);
        send_word(REQ_PEEK_L, '0, '0);
        send_word(REQ_PEEK_R, '0, '0);
        send_word(REQ_GET,    10'd0, '0);
        send_word(REQ_GET,    10'd2, '0);
        send_word(REQ_GET,    10'd3, '0);
        send_word(REQ_GET,    10'h3FF, '0);
        send_word(REQ_SET,    10'd1, 32'h8000_0001);
        send_word(REQ_SET,    10'h3FF, 32'h1234_5678);
        send_word(REQ_GET,    10'd1, '0);
        send_word(REQ_POP_R,  '0, 32'hFFFF_FFFF);
        send_word(REQ_POP_L,  '0, '0);
        send_word(REQ_PEEK_R, '0, '0);
        send_word(REQ_POP_L,  '0, '0);
        send_word(REQ_POP_L,  '0, '0);
        send_word(REQ_PUSH_R, '0, 32'h7FFF_FFFF);
        send_word(REQ_POP_R,  '0, '0);

        repeat (40) random_request();
        hold_until_drained();

        // fill to capacity, refuse pushes when full, then pop a little from both ends
        while (level < CAPACITY) begin
            if ($urandom_range(0, 31) == 0) begin
                pos = (level == 0) ? '0 : POS_W'($urandom_range(0, level - 1));
                send_word($urandom_range(0, 1) ? REQ_GET : REQ_SET, pos, $urandom);
            end else
                send_word($urandom_range(0, 1) ? REQ_PUSH_R : REQ_PUSH_L,
                          POS_W'($urandom_range(0, CAPACITY - 1)), $urandom);
        end
        send_word(REQ_PUSH_L, '0, $urandom);
        send_word(REQ_PUSH_R, '0, $urandom);
        send_word(REQ_GET,    10'h3FF, '0);
        send_word(REQ_SET,    10'h3FF, 32'hFFFF_FFFF);
        send_word(REQ_GET,    10'h3FF, '0);
        send_word(REQ_PEEK_L, '0, '0);
        send_word(REQ_PEEK_R, '0, '0);
        while (level > CAPACITY - 24) begin
            if ($urandom_range(0, 9) == 0)
                send_word($urandom_range(0, 1) ? REQ_GET : REQ_SET,
                          POS_W'($urandom_range(0, level - 1)), $urandom);
            else
                send_word($urandom_range(0, 1) ? REQ_POP_R : REQ_POP_L,
                          POS_W'($urandom_range(0, CAPACITY - 1)), $urandom);
        end

        // closing stretch at full rate on both sides
        send_gaps   = 1'b0;
        sink_stalls = 1'b0;
        repeat (40) random_request();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dqi_pkg.sv
rtl/dqi_ram.sv
rtl/dqi_ctrl.sv
rtl/double_ended_queue_indexed.sv
rtl/dqi_checker.sv
sim/dqi_result_checker.sv
sim/double_ended_queue_indexed_test.sv
